// ===== hdl/flt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fraction reduction package
// Shared widths and the command and status groups that pass between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package flt_pkg;

   localparam int OP_W  = 16;
   localparam int CNT_W = $clog2(OP_W);

   typedef logic [OP_W-1:0]  operand_type;
   typedef logic [CNT_W-1:0] count_type;

   typedef struct packed {
      logic load;
      logic special;
      logic gcd_step;
      logic latch_g;
      logic div_load;
      logic div_sel_den;
      logic div_step;
      logic store_num;
      logic store_den;
   } flt_cmd_type;

   typedef struct packed {
      logic special;
      logic gcd_done;
      logic div_last;
   } flt_status_type;

endpackage

// ===== hdl/fraction_lowest_terms.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fraction lowest terms
// Reduces an unsigned fraction by its greatest common divisor (binary GCD,
// then two restoring divisions on one shared divider).
// With a zero operand the strobe follows the operand check directly.
// Otherwise it follows the one-step GCD loop and the two divisions on the
// one-bit-per-cycle divider.
// A new request is taken the cycle after the strobe; the receiver cannot stall.
// Synchronous reset returns the controller to idle; results are not cleared.
// ----------------------------------------------------------------------------
module fraction_lowest_terms (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  flt_pkg::operand_type req_numerator,
   input  flt_pkg::operand_type req_denominator,
   output logic                 rsp_valid,
   output flt_pkg::operand_type rsp_reduced_numerator,
   output flt_pkg::operand_type rsp_reduced_denominator,
   output flt_pkg::operand_type rsp_common_divisor,
   output logic                 rsp_status
);
   import flt_pkg::*;

   flt_cmd_type    cmd;
   flt_status_type stat;

   flt_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .stat      (stat)
   );

   flt_datapath u_datapath (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .stat                    (stat),
      .req_numerator           (req_numerator),
      .req_denominator         (req_denominator),
      .rsp_reduced_numerator   (rsp_reduced_numerator),
      .rsp_reduced_denominator (rsp_reduced_denominator),
      .rsp_common_divisor      (rsp_common_divisor),
      .rsp_status              (rsp_status)
   );

endmodule

// ===== hdl/flt_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fraction reduction datapath
// Operand capture, binary GCD registers, a shared restoring divider and the
// result registers.
// ----------------------------------------------------------------------------
module flt_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  flt_pkg::flt_cmd_type   cmd,
   output flt_pkg::flt_status_type stat,
   input  flt_pkg::operand_type   req_numerator,
   input  flt_pkg::operand_type   req_denominator,
   output flt_pkg::operand_type   rsp_reduced_numerator,
   output flt_pkg::operand_type   rsp_reduced_denominator,
   output flt_pkg::operand_type   rsp_common_divisor,
   output logic                   rsp_status
);
   import flt_pkg::*;

   operand_type num_ff, den_ff, a_ff, b_ff, g_ff;
   count_type   k_ff, cnt_ff;
   operand_type rem_ff, rem_in, quo_ff, quo_in;
   operand_type rn_ff, rd_ff, gd_ff;
   logic        st_ff;
   logic [OP_W:0] trial;
   logic        fits;

   always_comb begin
      trial  = {rem_ff, quo_ff[OP_W-1]};
      fits   = (trial >= {1'b0, g_ff});
      rem_in = fits ? OP_W'(trial - {1'b0, g_ff}) : trial[OP_W-1:0];
      quo_in = {quo_ff[OP_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         num_ff <= req_numerator;
         den_ff <= req_denominator;
         a_ff   <= req_numerator;
         b_ff   <= req_denominator;
         k_ff   <= '0;
      end
      if (cmd.gcd_step) begin
         if (!a_ff[0] && !b_ff[0]) begin
            a_ff <= a_ff >> 1;
            b_ff <= b_ff >> 1;
            k_ff <= k_ff + 1'b1;
         end else if (!a_ff[0]) begin
            a_ff <= a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_ff <= b_ff >> 1;
         end else if (a_ff > b_ff) begin
            a_ff <= a_ff - b_ff;
         end else begin
            b_ff <= b_ff - a_ff;
         end
      end
      if (cmd.latch_g) begin
         g_ff <= a_ff << k_ff;
      end
      if (cmd.div_load) begin
         rem_ff <= '0;
         quo_ff <= cmd.div_sel_den ? den_ff : num_ff;
         cnt_ff <= CNT_W'(OP_W - 1);
      end
      if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         cnt_ff <= cnt_ff - 1'b1;
      end
      if (cmd.special) begin
         if (den_ff == '0) begin
            rn_ff <= num_ff;
            rd_ff <= '0;
            gd_ff <= '0;
            st_ff <= 1'b1;
         end else begin
            rn_ff <= '0;
            rd_ff <= OP_W'(1);
            gd_ff <= den_ff;
            st_ff <= 1'b0;
         end
      end
      if (cmd.store_num) begin
         rn_ff <= quo_in;
      end
      if (cmd.store_den) begin
         rd_ff <= quo_in;
         gd_ff <= g_ff;
         st_ff <= 1'b0;
      end
   end

   assign stat.special  = (num_ff == '0) || (den_ff == '0);
   assign stat.gcd_done = (a_ff == b_ff);
   assign stat.div_last = (cnt_ff == '0);

   assign rsp_reduced_numerator   = rn_ff;
   assign rsp_reduced_denominator = rd_ff;
   assign rsp_common_divisor      = gd_ff;
   assign rsp_status              = st_ff;

`ifndef SYNTHESIS
   a_gcd_nonzero : assert property (@(posedge clock) disable iff (reset)
      cmd.gcd_step |-> (a_ff != '0) && (b_ff != '0))
      else $error("GCD step with a zero operand");
   a_div_nonzero : assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (g_ff != '0))
      else $error("Division by a zero divisor");
   a_special_zero : assert property (@(posedge clock) disable iff (reset)
      cmd.special |-> (num_ff == '0) || (den_ff == '0))
      else $error("Special result taken with both operands nonzero");
`endif

endmodule

// ===== hdl/flt_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fraction reduction controller
// Sequences operand checks, the GCD iteration and the two divisions, and
// marks the result for one cycle.
// ----------------------------------------------------------------------------
module flt_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   output logic                    rsp_valid,
   output flt_pkg::flt_cmd_type    cmd,
   input  flt_pkg::flt_status_type stat
);
   import flt_pkg::*;

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_CHECK     = 3'd1;
   localparam logic [2:0] S_GCD       = 3'd2;
   localparam logic [2:0] S_DIVN      = 3'd3;
   localparam logic [2:0] S_DIVD_INIT = 3'd4;
   localparam logic [2:0] S_DIVD      = 3'd5;
   localparam logic [2:0] S_RESP      = 3'd6;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.special) begin
               cmd.special = 1'b1;
               state_in    = S_RESP;
            end else begin
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            if (stat.gcd_done) begin
               cmd.latch_g  = 1'b1;
               cmd.div_load = 1'b1;
               state_in     = S_DIVN;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         S_DIVN: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               cmd.store_num = 1'b1;
               state_in      = S_DIVD_INIT;
            end
         end
         S_DIVD_INIT: begin
            cmd.div_load    = 1'b1;
            cmd.div_sel_den = 1'b1;
            state_in        = S_DIVD;
         end
         S_DIVD: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               cmd.store_den = 1'b1;
               state_in      = S_RESP;
            end
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

`ifndef SYNTHESIS
   a_strobe_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("Result strobe longer than one cycle");
   a_load_idle : assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> busy)
      else $error("Request taken without the block going busy");
   a_store_order : assert property (@(posedge clock) disable iff (reset)
      cmd.store_den |=> rsp_valid)
      else $error("Result not presented after the last division");
`endif

endmodule
